// ===== hw/rtl/tpst_pkg.sv =====
// Package: shared constants and controller/datapath types for the permutation table.
`default_nettype none

package tpst_pkg;

  localparam int MAX_TASKS = 64;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int POS_W     = 6;
  localparam int ID_W      = 7;
  localparam int LEN_W     = 7;
  localparam int CNT_W     = 7;

  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_TASKS);
  localparam logic [LEN_W-1:0] LEN_RESET = (64 > MAX_TASKS) ? LEN_W'(MAX_TASKS) : LEN_W'(64);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_EVAL,
    ST_SCAN,
    ST_FINISH
  } tpst_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic scan_start;
    logic scan_step;
    logic load_res;
  } tpst_cmd_t;

  typedef struct packed {
    logic complete;
    logic scan_done;
    logic out_busy;
  } tpst_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tpst_if.sv =====
// Interfaces: input item channel and result channel, valid/ready handshake.
`default_nettype none

interface tpst_in_if;
  logic                      valid;
  logic                      ready;
  logic [tpst_pkg::POS_W-1:0] slot_position;
  logic [tpst_pkg::ID_W-1:0]  task_id;

  modport source (output valid, output slot_position, output task_id, input ready);
  modport sink   (input valid, input slot_position, input task_id, output ready);
endinterface

interface tpst_out_if;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic [tpst_pkg::CNT_W-1:0] filled_count;
  logic                      complete;
  logic                      valid_res;

  modport source (output valid, output accepted, output filled_count, output complete,
                  output valid_res, input ready);
  modport sink   (input valid, input accepted, input filled_count, input complete,
                  input valid_res, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tpst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tpst_datapath.sv =====
// Datapath: length register, valid bits, fill counter, table memory, scan and result register.
`default_nettype none

module tpst_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [tpst_pkg::LEN_W-1:0] cfg_data,
  input  wire logic [tpst_pkg::POS_W-1:0] in_pos,
  input  wire logic [tpst_pkg::ID_W-1:0]  in_id,
  input  wire logic                       out_ready,
  input  wire tpst_pkg::tpst_cmd_t        cmd,
  output tpst_pkg::tpst_sts_t             sts,
  output logic                            out_valid,
  output logic                            out_accepted,
  output logic      [tpst_pkg::CNT_W-1:0] out_filled_count,
  output logic                            out_complete,
  output logic                            out_valid_res
);
  import tpst_pkg::*;

  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [MAX_TASKS-1:0] vld_r, vld_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic                 acc_r, acc_nxt;
  logic [MAX_TASKS-1:0] seen_r, seen_nxt;
  logic [LEN_W-1:0]     iss_r, iss_nxt;
  logic                 pend_r, pend_nxt;
  logic                 dup_r, dup_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 res_acc_r, res_acc_nxt;
  logic [CNT_W-1:0]     res_cnt_r, res_cnt_nxt;
  logic                 res_cmp_r, res_cmp_nxt;
  logic                 res_val_r, res_val_nxt;

  logic             ok;
  logic             complete;
  logic             re;
  logic [IDX_W-1:0] widx;
  logic [IDX_W-1:0] sidx;
  logic [ID_W-1:0]  rd_data;
  logic [ID_W-1:0]  rd_dec;

  assign widx     = IDX_W'(pos_r);
  assign ok       = (LEN_W'(pos_r) < len_r) && (id_r != '0) && (id_r <= ID_W'(len_r));
  assign complete = (len_r != '0) && (CNT_W'(len_r) == cnt_r);
  assign re       = cmd.scan_step && (iss_r < len_r);
  assign rd_dec   = rd_data - ID_W'(1);
  assign sidx     = rd_dec[IDX_W-1:0];

  tpst_ram #(
    .WIDTH(ID_W),
    .DEPTH(MAX_TASKS)
  ) u_table (
    .clk  (clk),
    .we   (cmd.commit && ok),
    .waddr(widx),
    .wdata(id_r),
    .re   (re),
    .raddr(iss_r[IDX_W-1:0]),
    .rdata(rd_data)
  );

  always_comb begin
    len_nxt     = len_r;
    vld_nxt     = vld_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    id_nxt      = id_r;
    acc_nxt     = acc_r;
    seen_nxt    = seen_r;
    iss_nxt     = iss_r;
    pend_nxt    = re;
    dup_nxt     = dup_r;
    res_acc_nxt = res_acc_r;
    res_cnt_nxt = res_cnt_r;
    res_cmp_nxt = res_cmp_r;
    res_val_nxt = res_val_r;

    // a length write empties the table
    if (cfg_we) begin
      len_nxt = (cfg_data > LEN_MAX) ? LEN_MAX : cfg_data;
      vld_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.capture) begin
      pos_nxt = in_pos;
      id_nxt  = in_id;
    end
    if (cmd.commit) begin
      acc_nxt = ok;
      if (ok) begin
        vld_nxt[widx] = 1'b1;
        if (!vld_r[widx]) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
    end
    if (cmd.scan_start) begin
      seen_nxt = '0;
      iss_nxt  = '0;
      dup_nxt  = 1'b0;
    end
    if (re) begin
      iss_nxt = iss_r + LEN_W'(1);
    end
    // check each returned entry against the seen bitmap
    if (pend_r) begin
      if (seen_r[sidx]) begin
        dup_nxt = 1'b1;
      end
      seen_nxt[sidx] = 1'b1;
    end
    if (cmd.load_res) begin
      res_acc_nxt = acc_r;
      res_cnt_nxt = cnt_r;
      res_cmp_nxt = complete;
      res_val_nxt = complete && !dup_r;
    end
    out_vld_nxt = cmd.load_res || (out_vld_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= LEN_RESET;
      vld_r     <= '0;
      cnt_r     <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      len_r     <= len_nxt;
      vld_r     <= vld_nxt;
      cnt_r     <= cnt_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    id_r      <= id_nxt;
    acc_r     <= acc_nxt;
    seen_r    <= seen_nxt;
    iss_r     <= iss_nxt;
    dup_r     <= dup_nxt;
    res_acc_r <= res_acc_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_cmp_r <= res_cmp_nxt;
    res_val_r <= res_val_nxt;
  end

  assign sts.complete  = complete;
  assign sts.scan_done = (iss_r == len_r) && !pend_r;
  assign sts.out_busy  = out_vld_r && !out_ready;

  assign out_valid        = out_vld_r;
  assign out_accepted     = res_acc_r;
  assign out_filled_count = res_cnt_r;
  assign out_complete     = res_cmp_r;
  assign out_valid_res    = res_val_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tpst_ctrl.sv =====
// Controller: state machine that sequences write, table scan and result load.
`default_nettype none

module tpst_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tpst_pkg::tpst_sts_t sts,
  output tpst_pkg::tpst_cmd_t      cmd
);
  import tpst_pkg::*;

  tpst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_EVAL;
      end
      ST_EVAL: begin
        // scan only a full table; otherwise the result is already known
        cmd.scan_start = 1'b1;
        state_nxt      = sts.complete ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_res = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/task_sequence_permutation_table.sv =====
// Top level: task sequence permutation table, controller plus datapath.
//
//  channel  | dir | payload                                         | transfer
//  ---------+-----+-------------------------------------------------+----------------------
//  in_chan  | in  | slot_position[5:0], task_id[6:0]                | valid & ready
//  out_chan | out | accepted, filled_count[6:0], complete, valid_res | valid & ready
//  cfg      | in  | cfg_data[6:0] (task_count)                      | cfg_we, no wait
//
//  An item passes the write and evaluate states to a loaded result, and the scan
//  state too when the write leaves the table full: the validity scan reads one
//  table entry per cycle, up to the effective length (task_count capped at 64),
//  through the single read port of the table memory; the next item is taken in
//  the cycle after the result load. Reset (synchronous, rst_n low) empties the table
//  at once through per-entry valid bits and sets task_count to 64; no clearing pass
//  is needed. The result register decouples the sides: the next item is taken while
//  a result waits, and only the loading of its own result stalls on out_chan.
`default_nettype none

module task_sequence_permutation_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [tpst_pkg::LEN_W-1:0] cfg_data,
  tpst_in_if.sink                         in_chan,
  tpst_out_if.source                      out_chan
);
  import tpst_pkg::*;

  tpst_cmd_t cmd;
  tpst_sts_t sts;

  // sequencing: accept, write, decide on scan, scan, load result
  tpst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_chan.valid),
    .in_ready(in_chan.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // storage, fill count, duplicate scan and result register
  tpst_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_pos          (in_chan.slot_position),
    .in_id           (in_chan.task_id),
    .out_ready       (out_chan.ready),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_chan.valid),
    .out_accepted    (out_chan.accepted),
    .out_filled_count(out_chan.filled_count),
    .out_complete    (out_chan.complete),
    .out_valid_res   (out_chan.valid_res)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tpst_checker.sv =====
// Checker: port-level assertions for the permutation table, bound to the top level.
`default_nettype none

module tpst_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_accepted,
  input wire logic [tpst_pkg::CNT_W-1:0] out_filled_count,
  input wire logic                       out_complete,
  input wire logic                       out_valid_res
);
  import tpst_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filled_count) &&
                                $stable(out_accepted) && $stable(out_valid_res))
    else $error("stalled result changed");

  // one item in flight: no item right after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in work");

  a_valid_needs_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_complete)
    else $error("valid_res without complete");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_filled_count <= CNT_W'(MAX_TASKS))
    else $error("filled_count above table size");

  a_complete_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_complete |-> out_filled_count != '0)
    else $error("complete with empty table");

endmodule

bind task_sequence_permutation_table tpst_checker u_tpst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_accepted    (out_chan.accepted),
  .out_filled_count(out_chan.filled_count),
  .out_complete    (out_chan.complete),
  .out_valid_res   (out_chan.valid_res)
);

`default_nettype wire

// ===== sim/tb_task_sequence_permutation_table.sv =====
// Testbench for the task sequence permutation table: scoreboard class, drivers and checks.
`timescale 1ns / 100ps

typedef struct packed {
  logic                       accepted;
  logic [tpst_pkg::CNT_W-1:0] filled_count;
  logic                       complete;
  logic                       valid_res;
} perm_result_t;

// Mirror of the table: predicts one result per accepted item and checks results in order.
class perm_scoreboard;
  logic [tpst_pkg::LEN_W-1:0] task_count;
  int unsigned                sched_len;
  logic [tpst_pkg::ID_W-1:0]  slot_ids [tpst_pkg::MAX_TASKS];
  int unsigned                fill_count;
  perm_result_t               pending_results [$];
  int unsigned                errors;
  int unsigned                checked;

  function new();
    errors  = 0;
    checked = 0;
    set_length(tpst_pkg::LEN_RESET);
  endfunction

  // Any length write empties the table; lengths above the table size saturate.
  function void set_length(logic [tpst_pkg::LEN_W-1:0] len);
    task_count = len;
    sched_len  = (len > tpst_pkg::MAX_TASKS) ? tpst_pkg::MAX_TASKS : len;
    foreach (slot_ids[i]) slot_ids[i] = '0;
    fill_count = 0;
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  function void note_item(logic [tpst_pkg::POS_W-1:0] pos, logic [tpst_pkg::ID_W-1:0] id);
    perm_result_t exp_res;
    bit           seen [tpst_pkg::MAX_TASKS+1];
    bit           ok;
    bit           distinct;
    ok = (pos < sched_len) && (id != 0) && (id <= sched_len);
    if (ok) begin
      if (slot_ids[pos] == 0) fill_count++;
      slot_ids[pos] = id;
    end
    exp_res.accepted     = ok;
    exp_res.filled_count = fill_count[tpst_pkg::CNT_W-1:0];
    exp_res.complete     = (sched_len != 0) && (fill_count == sched_len);
    distinct = exp_res.complete;
    foreach (seen[i]) seen[i] = 1'b0;
    for (int i = 0; i < sched_len && distinct; i++) begin
      if (slot_ids[i] == 0 || slot_ids[i] > sched_len || seen[slot_ids[i]]) distinct = 1'b0;
      else seen[slot_ids[i]] = 1'b1;
    end
    exp_res.valid_res = distinct;
    pending_results.push_back(exp_res);
  endfunction

  function void check_result(perm_result_t got);
    perm_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("unexpected result: accepted=%0d filled_count=%0d complete=%0d valid_res=%0d",
             got.accepted, got.filled_count, got.complete, got.valid_res);
      errors++;
      return;
    end
    exp_res = pending_results.pop_front();
    checked++;
    if (got.accepted !== exp_res.accepted) begin
      $error("accepted: expected %0d, got %0d", exp_res.accepted, got.accepted);
      errors++;
    end
    if (got.filled_count !== exp_res.filled_count) begin
      $error("filled_count: expected %0d, got %0d", exp_res.filled_count, got.filled_count);
      errors++;
    end
    if (got.complete !== exp_res.complete) begin
      $error("complete: expected %0d, got %0d", exp_res.complete, got.complete);
      errors++;
    end
    if (got.valid_res !== exp_res.valid_res) begin
      $error("valid_res: expected %0d, got %0d", exp_res.valid_res, got.valid_res);
      errors++;
    end
  endfunction
endclass

module tb_task_sequence_permutation_table;

  localparam int CYCLE_LIMIT   = 1500000;
  localparam int PHASE_COUNT   = 28;
  localparam int PHASE_ITEMS   = 42;
  localparam int DRAIN_CYCLES  = 80;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [tpst_pkg::LEN_W-1:0] cfg_data;

  tpst_in_if  in_if ();
  tpst_out_if out_if ();

  perm_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned items_sent;
  int unsigned length_writes;
  int unsigned cycle_count;

  task_sequence_permutation_table uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // 12 ns clock, rising edge at 6 ns into each period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: end the run with an error once the cycle count passes the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: drop ready at random, per the current stall rate.
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result monitor: check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result('{accepted:     out_if.accepted,
                        filled_count: out_if.filled_count,
                        complete:     out_if.complete,
                        valid_res:    out_if.valid_res});
    end
  end

  // Offer one item; idle first at random, hold it until the block takes it.
  // Entered and left just after a falling edge.
  task automatic send_item(logic [tpst_pkg::POS_W-1:0] pos, logic [tpst_pkg::ID_W-1:0] id);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.slot_position <= pos;
    in_if.task_id       <= id;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(pos, id);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every predicted result has been seen.
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Write task_count only while the block is idle; the write also empties the table.
  task automatic program_length(logic [tpst_pkg::LEN_W-1:0] len);
    hold_until_drained();
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_length(len);
    length_writes++;
  endtask

  // Noise item: any position, identifier often zero or beyond the length.
  task automatic send_noise(int unsigned len);
    logic [tpst_pkg::ID_W-1:0] id;
    case ($urandom_range(0, 3))
      0:       id = '0;
      1:       id = (len >= 127) ? 7'd127 : 7'($urandom_range(len + 1, 127));
      default: id = 7'($urandom_range(0, 127));
    endcase
    send_item(6'($urandom_range(0, 63)), id);
  endtask

  // One round of writes for the current length: mostly full permutations in random
  // order, some with a duplicate planted, plus random fills and noise.
  task automatic run_round(int unsigned len);
    int unsigned               slen;
    int unsigned               kind;
    int unsigned               j;
    int unsigned               k;
    logic [tpst_pkg::ID_W-1:0]  ids [tpst_pkg::MAX_TASKS];
    logic [tpst_pkg::POS_W-1:0] order [tpst_pkg::MAX_TASKS];
    logic [tpst_pkg::ID_W-1:0]  tmp_id;
    logic [tpst_pkg::POS_W-1:0] tmp_pos;
    slen = (len > tpst_pkg::MAX_TASKS) ? tpst_pkg::MAX_TASKS : len;
    kind = (slen == 0) ? 9 : $urandom_range(0, 9);
    if (kind <= 5) begin
      for (int i = 0; i < slen; i++) begin
        ids[i]   = 7'(i + 1);
        order[i] = 6'(i);
      end
      // Shuffle identifiers and write order independently.
      for (int i = slen - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp_id  = ids[i];   ids[i]   = ids[j];   ids[j]   = tmp_id;
        k = $urandom_range(0, i);
        tmp_pos = order[i]; order[i] = order[k]; order[k] = tmp_pos;
      end
      if (slen > 1 && $urandom_range(0, 3) == 0) begin
        j = $urandom_range(0, slen - 1);
        k = $urandom_range(0, slen - 1);
        ids[j] = ids[k];
      end
      for (int i = 0; i < slen; i++) begin
        if ($urandom_range(0, 15) == 0) send_noise(len);
        send_item(order[i], ids[i]);
      end
      // Overwrite a few filled slots: may break or repair the permutation.
      repeat ($urandom_range(0, 2)) begin
        send_item(6'($urandom_range(0, slen - 1)), 7'($urandom_range(1, slen)));
      end
    end else if (kind <= 7) begin
      repeat (slen) send_item(6'($urandom_range(0, slen - 1)), 7'($urandom_range(1, slen)));
    end else begin
      repeat (8) send_noise(len);
    end
  endtask

  function automatic logic [tpst_pkg::LEN_W-1:0] pick_length(int unsigned phase);
    case (phase)
      0: return 7'd64;
      1: return 7'd1;
      2: return 7'd0;
      3: return 7'd127;
      default: begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: return 7'($urandom_range(1, 8));
          6:                return 7'($urandom_range(9, 63));
          7:                return 7'd64;
          8:                return 7'($urandom_range(65, 127));
          default:          return 7'd0;
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned                phase_items;
    logic [tpst_pkg::LEN_W-1:0] phase_len;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    in_if.valid         = 1'b0;
    in_if.slot_position = '0;
    in_if.task_id       = '0;
    out_if.ready        = 1'b1;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    items_sent          = 0;
    length_writes       = 0;
    cycle_count         = 0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset length of 64: last slot with largest id, zero id,
    // ids beyond the length, then an overwrite that must not raise the count.
    send_item(6'd63, 7'd64);
    send_item(6'd0,  7'd0);
    send_item(6'd0,  7'd65);
    send_item(6'd5,  7'd127);
    send_item(6'd0,  7'd1);
    send_item(6'd0,  7'd2);

    // Length zero: everything is rejected, never complete.
    program_length(7'd0);
    send_item(6'd0,  7'd1);
    send_item(6'd63, 7'd64);

    // Length one: a single write completes a valid table.
    program_length(7'd1);
    send_item(6'd0, 7'd1);
    send_item(6'd1, 7'd1);
    send_item(6'd0, 7'd2);
    send_item(6'd0, 7'd1);

    // Length two: complete with a duplicate, then repaired.
    program_length(7'd2);
    send_item(6'd0, 7'd1);
    send_item(6'd1, 7'd1);
    send_item(6'd1, 7'd2);

    // Length above the table size saturates at 64.
    program_length(7'd127);
    send_item(6'd63, 7'd64);
    send_item(6'd0,  7'd65);
    send_item(6'd0,  7'd127);
    program_length(7'd65);
    send_item(6'd10, 7'd64);

    // Random part: rotate idle modes, draw a length per phase, clear now and then.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      phase_len   = pick_length(phase);
      program_length(phase_len);
      phase_items = items_sent + PHASE_ITEMS;
      while (items_sent < phase_items) begin
        if ($urandom_range(0, 7) == 0) hold_until_drained();
        if ($urandom_range(0, 3) == 0) program_length(phase_len);
        run_round(phase_len);
      end
    end

    // Drain: stop sending, wait for the last results, then a quiet tail.
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d items over %0d length writes, checked %0d results.",
             items_sent, length_writes, sb.checked);
    $display("Covered lengths 0, 1, 2, small, 64 and saturated, under four idle modes.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tpst_pkg.sv
hw/rtl/tpst_if.sv
hw/rtl/tpst_ram.sv
hw/rtl/tpst_datapath.sv
hw/rtl/tpst_ctrl.sv
hw/rtl/task_sequence_permutation_table.sv
hw/rtl/tpst_checker.sv
sim/tb_task_sequence_permutation_table.sv
